// ===== hw/rtl/mei_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei_pkg: shared types and constants
// Item structs, sequencer states, register codes and the request and response
// groups of the shared MAC and divider units.
// ----------------------------------------------------------------------------
package mei_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 32;
	localparam int ACC_W         = 136;   // magnitude of 8 full products plus sign
	localparam int TERM_CAP      = 50;

	localparam logic [3:0] DIM_RESET   = 4'd8;
	localparam logic [5:0] TERMS_RESET = 6'd10;
	localparam real        TOL_RESET   = 1.0e-7;

	// configuration register indexes
	localparam logic [1:0] CFG_DIM   = 2'd0;
	localparam logic [1:0] CFG_STEP  = 2'd1;
	localparam logic [1:0] CFG_TOL   = 2'd2;
	localparam logic [1:0] CFG_TERMS = 2'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic        command;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  out_row;
		logic [2:0]  out_col;
		logic [63:0] out_value;
		logic        last;
		logic [5:0]  terms_used;
		logic        converged;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_NORM_RD,
		ST_NORM_WR,
		ST_CHECK,
		ST_MM_RD,
		ST_MM_GO,
		ST_MM_WAIT,
		ST_SC_RD,
		ST_SC_GO,
		ST_SC_WAIT,
		ST_SC_DIV,
		ST_OUT_RD,
		ST_OUT_EMIT
	} state_t;

	typedef struct packed {
		logic        go;
		logic        first;   // clear the accumulator before this product
		logic [63:0] x;
		logic [63:0] y;
	} mac_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;     // accumulator, scaled and saturated
	} mac_rsp_t;

	typedef struct packed {
		logic        go;
		logic [63:0] value;
		logic [5:0]  den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

// ===== hw/rtl/mei_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei_mac: shared fixed-point multiply-accumulate
// Forms a 64x64 signed product from four 32x32 partial products, one per
// cycle, and adds it exactly into a wide accumulator. Output is the
// accumulator shifted down by FRAC_BITS (floor) and saturated to 64 bits.
// ----------------------------------------------------------------------------
module mei_mac import mei_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_req_t req,
	output mac_rsp_t rsp
);

	logic [63:0]        xm_q, ym_q;
	logic               neg_q;
	logic               run_q;
	logic [1:0]         ph_q;
	logic [63:0]        prod_s1;
	logic [1:0]         ph_s1;
	logic               pv_s1;
	logic               done_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [31:0]        mul_a, mul_b;
	logic [1:0]         shamt;
	logic [ACC_W-1:0]   ext;
	logic signed [ACC_W-1:0] scaled;
	logic [ACC_W-64:0]  top_bits;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ph_q   <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pv_s1  <= run_q;
			done_q <= pv_s1 && (ph_s1 == 2'd3);
			if (req.go) begin
				run_q <= 1'b1;
				ph_q  <= '0;
			end else if (run_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) run_q <= 1'b0;
			end
		end
	end

	// operand magnitudes and partial products
	assign mul_a = ph_q[0] ? xm_q[63:32] : xm_q[31:0];
	assign mul_b = ph_q[1] ? ym_q[63:32] : ym_q[31:0];

	always_ff @(posedge clk) begin
		if (req.go) begin
			xm_q  <= req.x[63] ? (64'd0 - req.x) : req.x;
			ym_q  <= req.y[63] ? (64'd0 - req.y) : req.y;
			neg_q <= req.x[63] ^ req.y[63];
		end
		prod_s1 <= mul_a * mul_b;
		ph_s1   <= ph_q;
	end

	// accumulate the shifted partial product
	assign shamt = {ph_s1[1] & ph_s1[0], ph_s1[1] ^ ph_s1[0]};
	assign ext   = ACC_W'(prod_s1) << {shamt, 5'b0};

	always_ff @(posedge clk) begin
		if (req.go && req.first) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= neg_q ? (acc_q - $signed(ext)) : (acc_q + $signed(ext));
		end
	end

	// scale and saturate
	assign scaled   = acc_q >>> FRAC_BITS;
	assign top_bits = scaled[ACC_W-1:63];

	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			rsp.res = scaled[63:0];
		end else begin
			rsp.res = acc_q[ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
	end

	assign rsp.busy = run_q | pv_s1;
	assign rsp.done = done_q;

endmodule

// ===== hw/rtl/mei_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei_div: signed value by small unsigned divisor
// Restoring division, one quotient bit per cycle, truncating
// toward zero. The result is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module mei_div import mei_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] q_q;
	logic [5:0]  rem_q;
	logic [5:0]  den_q;
	logic        neg_q;

	logic [6:0]  trial;
	logic        fits;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 6'd63);
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) run_q <= 1'b0;
			end
		end
	end

	// one quotient bit a cycle
	assign trial = {rem_q, q_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.go) begin
			q_q   <= req.value[63] ? (64'd0 - req.value) : req.value;
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.value[63];
		end else if (run_q) begin
			q_q   <= {q_q[62:0], fits};
			rem_q <= fits ? 6'(trial - {1'b0, den_q}) : trial[5:0];
		end
	end

	assign rsp.busy = run_q;
	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? (64'd0 - q_q) : q_q;

endmodule

// ===== hw/rtl/matrix_exp_integral_series.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_exp_integral_series: integral of exp(P t) by truncated Taylor series
// Loads P element by element, sums P^k t^(k+1)/(k+1)! until a term's
// infinity norm meets the tolerance or the term limit is hit, then emits
// the sum row-major.
// ----------------------------------------------------------------------------
// A load item leaves busy low. A start item keeps busy high while the
// sequencer zeroes the sum, sets the first term to t*I, then adds each term
// into the sum and measures its norm, forms the next as term*P scaled by t
// and divided by (k+2), and at the end emits the sum. The one shared 32x32
// multiplier (four partial products per multiply-accumulate) and the
// one-bit-per-cycle divider for the 1/(k+2) scaling do the arithmetic.
// Results come each after a read state, on result for a single cycle under
// result_strobe; the receiver cannot stall them and must take every one.
// ----------------------------------------------------------------------------
module matrix_exp_integral_series import mei_pkg::*; #(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    request,
	output out_item_t   result,
	output logic        result_strobe,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam logic [3:0]  MAX_DIM_C  = 4'(MAX_DIM);
	localparam logic [5:0]  TERM_CAP_C = 6'(TERM_CAP);
	localparam logic [63:0] STEP_RESET = 64'd1 << FRAC_BITS;
	localparam logic [62:0] TOL_RST    = 63'(longint'(TOL_RESET * (2.0 ** FRAC_BITS)));

	// configuration registers
	logic [3:0]  dim_q;
	logic [63:0] step_q;
	logic [62:0] tol_q;
	logic [5:0]  terms_q;

	// sequencer and loop state
	state_t      state_q, state_d;
	logic [IW-1:0] i_q, j_q, c_q, dlast_q;
	logic [5:0]  k_q, limit_q;
	logic [63:0] rs_q, norm_q;
	logic        conv_q;
	logic        strobe_q;
	out_item_t   result_q;

	// memories
	logic [63:0] mat_mem  [DEPTH];
	logic [63:0] sum_mem  [DEPTH];
	logic [63:0] term_mem [DEPTH];
	logic [63:0] prod_mem [DEPTH];
	logic [63:0] mat_rd_q, sum_rd_q, term_rd_q, prod_rd_q;

	logic          mat_we, sum_we, term_we, prod_we;
	logic [AW-1:0] term_wa;
	logic [63:0]   term_wd, sum_wd;

	mac_req_t mac_req;
	mac_rsp_t mac_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic i_last, j_last, c_last;
	logic load_ok;
	logic [3:0] dim_clamp;
	logic [5:0] limit_clamp;
	logic [63:0] rs_next;

	function automatic logic [63:0] magn(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if ((a[63] == b[63]) && (a[63] != r[63])) begin
			return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [63:0] usat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] r;
		r = {1'b0, a} + {1'b0, b};
		return r[64] ? {64{1'b1}} : r[63:0];
	endfunction

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q   <= DIM_RESET;
			step_q  <= STEP_RESET;
			tol_q   <= TOL_RST;
			terms_q <= TERMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIM:   dim_q   <= cfg_data[3:0];
				CFG_STEP:  step_q  <= cfg_data;
				CFG_TOL:   tol_q   <= cfg_data[62:0];
				CFG_TERMS: terms_q <= cfg_data[5:0];
			endcase
		end
	end

	// range clamps taken at start
	assign dim_clamp   = (dim_q == 4'd0) ? 4'd1 : ((dim_q > MAX_DIM_C) ? MAX_DIM_C : dim_q);
	assign limit_clamp = (terms_q == 6'd0) ? 6'd1 :
	                     ((terms_q > TERM_CAP_C) ? TERM_CAP_C : terms_q);

	assign i_last  = (i_q == dlast_q);
	assign j_last  = (j_q == dlast_q);
	assign c_last  = (c_q == dlast_q);
	assign load_ok = ({1'b0, request.row} < MAX_DIM_C) && ({1'b0, request.col} < MAX_DIM_C);
	assign rs_next = usat_add(rs_q, magn(term_rd_q));

	// memory ports
	always_ff @(posedge clk) begin
		if (mat_we) mat_mem[{request.row[IW-1:0], request.col[IW-1:0]}] <= request.value;
		mat_rd_q <= mat_mem[{j_q, c_q}];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[{i_q, j_q}] <= sum_wd;
		sum_rd_q <= sum_mem[{i_q, j_q}];
	end

	always_ff @(posedge clk) begin
		if (term_we) term_mem[term_wa] <= term_wd;
		term_rd_q <= term_mem[{i_q, j_q}];
	end

	always_ff @(posedge clk) begin
		if (prod_we) prod_mem[{i_q, c_q}] <= mac_rsp.res;
		prod_rd_q <= prod_mem[{i_q, c_q}];
	end

	// shared units
	mei_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	mei_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state and control
	always_comb begin
		state_d       = state_q;
		mat_we        = 1'b0;
		sum_we        = 1'b0;
		term_we       = 1'b0;
		prod_we       = 1'b0;
		term_wa       = {i_q, c_q};
		term_wd       = div_rsp.quo;
		sum_wd        = sat_add(sum_rd_q, term_rd_q);
		mac_req.go    = 1'b0;
		mac_req.first = 1'b1;
		mac_req.x     = prod_rd_q;
		mac_req.y     = step_q;
		div_req.go    = 1'b0;
		div_req.value = mac_rsp.res;
		div_req.den   = k_q + 6'd2;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (request.command == CMD_START) state_d = ST_INIT;
					else mat_we = load_ok;
				end
			end
			ST_INIT: begin
				sum_we  = 1'b1;
				sum_wd  = '0;
				term_we = 1'b1;
				term_wa = {i_q, j_q};
				term_wd = (i_q == j_q) ? step_q : 64'd0;
				if (i_last && j_last) state_d = ST_NORM_RD;
			end
			ST_NORM_RD: state_d = ST_NORM_WR;
			ST_NORM_WR: begin
				sum_we  = 1'b1;
				state_d = (i_last && j_last) ? ST_CHECK : ST_NORM_RD;
			end
			ST_CHECK: begin
				if (norm_q <= {1'b0, tol_q})        state_d = ST_OUT_RD;
				else if ((k_q + 6'd1) >= limit_q)   state_d = ST_OUT_RD;
				else                                state_d = ST_MM_RD;
			end
			ST_MM_RD: state_d = ST_MM_GO;
			ST_MM_GO: begin
				mac_req.go    = 1'b1;
				mac_req.first = (j_q == '0);
				mac_req.x     = term_rd_q;
				mac_req.y     = mat_rd_q;
				state_d       = ST_MM_WAIT;
			end
			ST_MM_WAIT: begin
				if (mac_rsp.done) begin
					prod_we = j_last;
					state_d = (i_last && j_last && c_last) ? ST_SC_RD : ST_MM_RD;
				end
			end
			ST_SC_RD: state_d = ST_SC_GO;
			ST_SC_GO: begin
				mac_req.go = 1'b1;
				state_d    = ST_SC_WAIT;
			end
			ST_SC_WAIT: begin
				if (mac_rsp.done) begin
					div_req.go = 1'b1;
					state_d    = ST_SC_DIV;
				end
			end
			ST_SC_DIV: begin
				if (div_rsp.done) begin
					term_we = 1'b1;
					state_d = (i_last && c_last) ? ST_NORM_RD : ST_SC_RD;
				end
			end
			ST_OUT_RD: state_d = ST_OUT_EMIT;
			ST_OUT_EMIT: state_d = (i_last && j_last) ? ST_IDLE : ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// loop counters, norm and termination state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			dlast_q <= '0;
			limit_q <= 6'd1;
			rs_q    <= '0;
			norm_q  <= '0;
			conv_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && (request.command == CMD_START)) begin
						dlast_q <= IW'(dim_clamp - 4'd1);
						limit_q <= limit_clamp;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_INIT, ST_OUT_EMIT: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					rs_q   <= '0;
					norm_q <= '0;
				end
				ST_NORM_WR: begin
					if (j_last) begin
						j_q    <= '0;
						i_q    <= i_last ? '0 : i_q + 1'b1;
						rs_q   <= '0;
						norm_q <= (rs_next > norm_q) ? rs_next : norm_q;
					end else begin
						j_q  <= j_q + 1'b1;
						rs_q <= rs_next;
					end
				end
				ST_CHECK: begin
					conv_q <= (norm_q <= {1'b0, tol_q});
					i_q    <= '0;
					j_q    <= '0;
					c_q    <= '0;
				end
				ST_MM_WAIT: begin
					if (mac_rsp.done) begin
						if (j_last) begin
							j_q <= '0;
							if (c_last) begin
								c_q <= '0;
								i_q <= i_last ? '0 : i_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_SC_DIV: begin
					if (div_rsp.done) begin
						if (c_last) begin
							c_q <= '0;
							i_q <= i_last ? '0 : i_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
						if (i_last && c_last) begin
							k_q    <= k_q + 6'd1;
							j_q    <= '0;
							rs_q   <= '0;
							norm_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else         strobe_q <= (state_q == ST_OUT_EMIT);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_EMIT) begin
			result_q.out_row    <= 3'(i_q);
			result_q.out_col    <= 3'(j_q);
			result_q.out_value  <= sum_rd_q;
			result_q.last       <= i_last && j_last;
			result_q.terms_used <= k_q + 6'd1;
			result_q.converged  <= conv_q;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;
	assign busy          = (state_q != ST_IDLE);

	// checks
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == ST_OUT_EMIT))
		else $error("result strobe without an emit cycle");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.last) |-> (state_q == ST_IDLE))
		else $error("last result while sequencer still busy");

	a_mac_not_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		mac_req.go |-> !mac_rsp.busy)
		else $error("MAC started while busy");

	a_div_not_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.go |-> !div_rsp.busy)
		else $error("divider started while busy");

endmodule

// ===== tb/matrix_exp_integral_series_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_exp_integral_series_test: self-checking bench for the Taylor-series
// integral of the matrix exponential
// Items go into a pending queue and a falling-edge driver sends them. A
// rising-edge monitor models every accepted item in fixed point and checks
// each result element, field by field, against the oldest expected one.
// Configuration is rewritten between phases once the block has gone idle.
// ----------------------------------------------------------------------------
module matrix_exp_integral_series_test;
	import mei_pkg::*;

	localparam int  CYCLE_LIMIT = 20000000;
	localparam int  DRAIN_WAIT  = 40;
	localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    request;
	out_item_t   result;
	logic        result_strobe;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	matrix_exp_integral_series dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result(result), .result_strobe(result_strobe),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	in_item_t  pending_items[$];
	out_item_t want_elems[$];

	// shadow of the configuration and the matrix
	logic [3:0]  dim_shadow;
	logic [63:0] t_shadow;
	logic [62:0] tol_shadow;
	logic [5:0]  terms_shadow;
	logic [63:0] p_mat[64];
	logic [63:0] sum_mat[64];
	logic [63:0] term_mat[64];
	logic [63:0] prod_mat[64];

	int errors, cycles, idle_pct, loads_sent, starts_sent, elems_checked;
	logic took;

	// 64x64 signed products summed exactly, floored by FRAC_BITS, saturated
	function automatic logic [63:0] fx_scale(input logic signed [135:0] acc);
		logic signed [135:0] s;
		s = acc >>> FRAC_BITS_DEF;
		if (s[135:63] == '0 || s[135:63] == '1)
			return s[63:0];
		return s[135] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
	endfunction

	function automatic logic signed [135:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic signed [135:0] wa, wb;
		wa = $signed(a);
		wb = $signed(b);
		return wa * wb;
	endfunction

	function automatic logic [63:0] fx_add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			return a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		return r;
	endfunction

	function automatic logic [63:0] fx_div_trunc(input logic [63:0] v, input logic [63:0] den);
		logic [63:0] q;
		q = (v[63] ? -v : v) / den;
		return v[63] ? -q : q;
	endfunction

	// full series for one start item, results pushed row-major
	function automatic void series_sum_predict();
		int d, lim, k, i, j, c;
		logic conv;
		logic [63:0] norm, mg;
		logic [64:0] rs;
		logic signed [135:0] acc;
		out_item_t o;
		d = (dim_shadow == 0) ? 1 : (dim_shadow > MAX_DIM_DEF) ? MAX_DIM_DEF : dim_shadow;
		lim = (terms_shadow == 0) ? 1 : (terms_shadow > TERM_CAP) ? TERM_CAP : terms_shadow;
		conv = 1'b0;
		k = 0;
		for (i = 0; i < 64; i++) begin
			sum_mat[i] = '0;
			term_mat[i] = '0;
		end
		for (i = 0; i < d; i++)
			term_mat[i*8+i] = t_shadow;
		forever begin
			// accumulate the term and measure its infinity norm
			norm = '0;
			for (i = 0; i < d; i++) begin
				rs = '0;
				for (j = 0; j < d; j++) begin
					sum_mat[i*8+j] = fx_add_sat(sum_mat[i*8+j], term_mat[i*8+j]);
					mg = term_mat[i*8+j][63] ? -term_mat[i*8+j] : term_mat[i*8+j];
					rs = rs + mg;
					if (rs[64]) rs = {1'b0, 64'hffff_ffff_ffff_ffff};
				end
				if (rs[63:0] > norm) norm = rs[63:0];
			end
			if (norm <= {1'b0, tol_shadow}) begin
				conv = 1'b1;
				break;
			end
			if (k + 1 >= lim) break;
			// next term = term * P * t / (k+2)
			for (i = 0; i < d; i++)
				for (c = 0; c < d; c++) begin
					acc = '0;
					for (j = 0; j < d; j++)
						acc = acc + fx_mul(term_mat[i*8+j], p_mat[j*8+c]);
					prod_mat[i*8+c] = fx_scale(acc);
				end
			for (i = 0; i < d; i++)
				for (c = 0; c < d; c++)
					term_mat[i*8+c] = fx_div_trunc(fx_scale(fx_mul(prod_mat[i*8+c], t_shadow)),
						64'(k + 2));
			k++;
		end
		for (i = 0; i < d; i++)
			for (j = 0; j < d; j++) begin
				o.out_row = i[2:0];
				o.out_col = j[2:0];
				o.out_value = sum_mat[i*8+j];
				o.last = (i == d-1 && j == d-1);
				o.terms_used = 6'(k + 1);
				o.converged = conv;
				want_elems.push_back(o);
			end
	endfunction

	// driver: one item at a time, changed on the falling edge
	always @(negedge clk) begin
		if (arst_n && (took || !start)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				request <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: accept items, check results
	always @(posedge clk) begin
		cycles <= cycles + 1;
		took <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			if (request.command == CMD_LOAD) begin
				p_mat[request.row*8 + request.col] = request.value;
				loads_sent++;
			end else begin
				series_sum_predict();
				starts_sent++;
			end
		end
		if (arst_n && result_strobe) begin
			if (want_elems.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d value %h", $time,
					result.out_row, result.out_col, result.out_value);
				errors++;
			end else begin
				out_item_t w;
				w = want_elems.pop_front();
				if (result.out_row !== w.out_row || result.out_col !== w.out_col ||
						result.out_value !== w.out_value || result.last !== w.last ||
						result.terms_used !== w.terms_used || result.converged !== w.converged) begin
					$display("%0t: mismatch expected r%0d c%0d %h last %b terms %0d conv %b",
						$time, w.out_row, w.out_col, w.out_value, w.last, w.terms_used,
						w.converged);
					$display("%0t:          actual   r%0d c%0d %h last %b terms %0d conv %b",
						$time, result.out_row, result.out_col, result.out_value, result.last,
						result.terms_used, result.converged);
					errors++;
				end
				elems_checked++;
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL matrix_exp_integral_series");
			$finish;
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DIM:   dim_shadow = data[3:0];
			CFG_STEP:  t_shadow = data;
			CFG_TOL:   tol_shadow = data[62:0];
			CFG_TERMS: terms_shadow = data[5:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] dim, input logic [63:0] t,
			input logic [63:0] tol, input logic [63:0] terms);
		cfg_write(CFG_DIM, dim);
		cfg_write(CFG_STEP, t);
		cfg_write(CFG_TOL, tol);
		cfg_write(CFG_TERMS, terms);
	endtask

	// let every queued item go and every result come, then settle
	task automatic drain();
		wait (pending_items.size() == 0 && want_elems.size() == 0);
		do @(posedge clk); while (start || busy);
		repeat (DRAIN_WAIT) @(posedge clk);
		while (busy || want_elems.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)   // about -2.0 .. -1.0
			return {{30{1'b0}}, 34'($urandom())} - 64'h0000_0002_0000_0000;
		if (pick < 85)   // small fractions
			return 64'($signed(32'($urandom()) >>> 8));
		return {32'($urandom()), 32'($urandom())};
	endfunction

	function automatic void push_load(input int r, input int c, input logic [63:0] v);
		in_item_t it;
		it.command = CMD_LOAD;
		it.row = r[2:0];
		it.col = c[2:0];
		it.value = v;
		pending_items.push_back(it);
	endfunction

	function automatic void push_start();
		in_item_t it;
		it.command = CMD_START;
		it.row = 3'($urandom());
		it.col = 3'($urandom());
		it.value = {32'($urandom()), 32'($urandom())};
		pending_items.push_back(it);
	endfunction

	initial begin
		int ph, n, d, hi;
		logic [63:0] tol, terms;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DIM;
		cfg_data = '0;
		took = 1'b0;
		errors = 0; cycles = 0; idle_pct = 0;
		loads_sent = 0; starts_sent = 0; elems_checked = 0;
		dim_shadow = DIM_RESET;
		t_shadow = ONE_Q;
		tol_shadow = 63'd429;
		terms_shadow = TERMS_RESET;
		for (int i = 0; i < 64; i++) p_mat[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// whole matrix written first, then a start at the reset settings
		for (int i = 0; i < 64; i++) push_load(i / 8, i % 8, rand_value() >>> 2);
		push_start();
		drain();

		// one by one: corner loads with extreme settings
		idle_pct = 56;
		set_config(0, 64'h7fff_ffff_ffff_ffff, 0, 63);   // dimension 0, limit above cap
		push_load(0, 0, 64'h7fff_ffff_ffff_ffff);
		push_start();
		push_load(0, 0, 64'h8000_0000_0000_0000);
		push_start();
		push_load(0, 0, 64'hffff_ffff_8000_0000);    // -0.5
		push_start();
		drain();
		set_config(15, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 0);
		push_load(7, 7, 64'h8000_0000_0000_0000);
		push_load(7, 0, 64'h7fff_ffff_ffff_ffff);
		push_start();
		drain();
		idle_pct = 0;
		set_config(2, -ONE_Q, 429, 50);
		push_load(0, 0, -ONE_Q);
		push_load(0, 1, ONE_Q >> 1);
		push_load(1, 0, 64'h0000_0000_4000_0000);
		push_load(1, 1, -(ONE_Q >> 2));
		push_start();
		drain();
		set_config(8, ONE_Q >> 3, 64'd1 << 20, 3);    // full size, few terms
		push_load(3, 4, ONE_Q);
		push_start();
		drain();

		// random phases, mostly small dimensions
		for (ph = 0; ph < 7; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 56;
				2: idle_pct = 0;
				default: idle_pct = 34;
			endcase
			d = $urandom_range(1, 4);
			hi = $urandom_range(99);
			if (hi < 10) terms = $urandom_range(51, 63);
			else if (hi < 20) terms = 0;
			else terms = $urandom_range(1, 12);
			if (terms > 12 && d > 2) d = 2;
			tol = ($urandom_range(3) == 0) ? {32'($urandom()), 32'($urandom())}
				: 64'($urandom_range(0, 1 << 24));
			set_config(($urandom_range(9) == 0) ? 64'($urandom_range(9, 15)) % 16 : d,
				($urandom_range(4) == 0) ? {32'($urandom()), 32'($urandom())}
					: rand_value(),
				tol, terms);
			if (dim_shadow > 4) set_config(d, t_shadow, tol, terms);
			n = $urandom_range(6, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(3) == 0)
					push_load($urandom_range(7), $urandom_range(7), rand_value());
				else
					push_load($urandom_range(d - 1), $urandom_range(d - 1), rand_value());
				if ($urandom_range(4) == 0) push_start();
			end
			push_start();
			drain();
		end

		$display("%0d loads, %0d series runs, %0d result elements checked, %0d errors",
			loads_sent, starts_sent, elems_checked, errors);
		if (errors == 0)
			$display("PASS matrix_exp_integral_series");
		else
			$display("FAIL matrix_exp_integral_series");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mei_pkg.sv
hw/rtl/mei_mac.sv
hw/rtl/mei_div.sv
hw/rtl/matrix_exp_integral_series.sv
tb/matrix_exp_integral_series_test.sv
